FILE: hdl/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared sizes, command codes and status struct of the buddy frame allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int ORDERS          = 11;
  localparam int TOP_CHUNKS      = 16;
  localparam int MAX_ALLOCATIONS = 64;
  localparam int FRAME_BYTES     = 4096;

  localparam int TOTAL_FRAMES = TOP_CHUNKS << (ORDERS - 1);
  localparam int FRAME_W      = 14;
  localparam int BYTES_W      = 32;
  localparam int ORD_W        = $clog2(ORDERS);
  localparam int CNT_W        = $clog2(TOTAL_FRAMES + 1);
  localparam int LEFT_W       = FRAME_W + 1;
  localparam int SLOT_W       = (MAX_ALLOCATIONS > 1) ? $clog2(MAX_ALLOCATIONS) : 1;
  localparam int CHUNK_W      = $clog2(TOP_CHUNKS + 1);
  localparam int CFG_W        = 5;
  localparam int GRANT_W      = 2 * FRAME_W;

  // first bit of the bitmap of one order
  function automatic int mark_base(int o);
    int b;
    b = 0;
    for (int k = 0; k < o; k++) b += TOTAL_FRAMES >> k;
    return b;
  endfunction

  localparam int MARK_BITS  = mark_base(ORDERS);
  localparam int MARK_WORDS = (MARK_BITS + 31) / 32;
  localparam int MARK_AW    = $clog2(MARK_WORDS);
  localparam int POS_W      = MARK_AW + 5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOT_FND  = 2'd3;

  localparam logic MODE_ALLOC = 1'b0;

  typedef enum logic [4:0] {
    OP_NONE, OP_CINIT, OP_CSTEP, OP_LOAD, OP_RES_NOSPACE, OP_RES_FULL,
    OP_RES_NOTFOUND, OP_SCAN_INIT, OP_SCAN_RD, OP_SCAN_HIT, OP_SCAN_NEXT,
    OP_MRD, OP_MWR, OP_TRIM, OP_GRANT, OP_FRD, OP_FHIT, OP_FNEXT, OP_CHUNK,
    OP_BRD, OP_BCLR, OP_MFINAL, OP_PUSH
  } dp_op_t;

  typedef struct packed {
    logic mode;
    logic fit;
    logic sel_found;
    logic table_full;
    logic scan_hit;
    logic trim_zero;
    logic trim_split;
    logic f_hit;
    logic f_last;
    logic left_zero;
    logic mo_top;
    logic buddy_set;
    logic sweep_last;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: hdl/buddy_frame_allocator.sv
// ----------------------------------------------------------------------------
// buddy_frame_allocator
// Buddy frame allocator with per-order free bitmaps and a grant table.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | contents
//  in_     | slave     | tvalid/tready      | tuser mode, tdata bytes + start
//  out_    | master    | tvalid/tready      | tuser status, tdata first + last
//  cfg_    | write     | we                 | usable top-order chunks
//
// one request at a time; an allocate reads and checks each bitmap word it scans,
// writes a mark back per trim step that returns a half, none per step keeping it;
// a free searches grant entries one by one, then returns each chunk, merging up.
// after reset and after each register write a clear pass over all MARK_WORDS
// words (1024) rewrites the bitmap RAM while in_tready stays low.
// a result waits in the output register; the next request stalls only at its own.
module buddy_frame_allocator (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [bfa_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic                      in_tuser,   // mode
  input  logic [47:0]               in_tdata,   // request_bytes, free_start
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [1:0]                out_tuser,  // status
  output logic [31:0]               out_tdata   // first_frame, final_frame
);
  import bfa_pkg::*;

  dp_op_t   op;
  dp_stat_t stat;
  logic [FRAME_W-1:0] first_frame, final_frame;

  bfa_ctrl u_ctrl (
    .clk, .rst_n, .cfg_we, .in_tvalid, .in_tready, .stat, .op
  );

  bfa_dp u_dp (
    .clk, .rst_n, .op, .stat, .cfg_we, .cfg_wdata,
    .in_mode(in_tuser),
    .in_bytes(in_tdata[BYTES_W-1:0]),
    .in_start(in_tdata[BYTES_W+FRAME_W-1:BYTES_W]),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_status(out_tuser),
    .out_first(first_frame),
    .out_final(final_frame)
  );

  assign out_tdata = {4'd0, final_frame, first_frame};

  // one request in flight: ready drops after every accepted beat
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while another is in work");

  a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_tready)
    else $error("request taken during clear pass");

  a_grant_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_OK |-> out_tdata[13:0] <= out_tdata[27:14])
    else $error("granted run ends before it starts");

endmodule

FILE: hdl/bfa_ram.sv
// ----------------------------------------------------------------------------
// bfa_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module bfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   addr,
  input  logic [WIDTH-1:0]           wdata,
  output logic [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: hdl/bfa_ctrl.sv
// ----------------------------------------------------------------------------
// bfa_ctrl
// Sequencer for clear pass, allocate scan and trim, free lookup and merging.
// ----------------------------------------------------------------------------
module bfa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  bfa_pkg::dp_stat_t stat,
  output bfa_pkg::dp_op_t   op
);
  import bfa_pkg::*;

  typedef enum logic [3:0] {
    S_CINIT, S_CLR, S_IDLE, S_DISP, S_SCAN_RD, S_SCAN_CHK, S_MRD, S_MWR,
    S_TRIM, S_FRD, S_FCHK, S_CHUNK, S_MERGE, S_BCHK, S_DONE
  } state_t;

  state_t state_r, state_nxt, ret_r, ret_nxt;

  assign in_tready = (state_r == S_IDLE) && !cfg_we;

  always_comb begin
    op        = OP_NONE;
    state_nxt = state_r;
    ret_nxt   = ret_r;
    unique case (state_r)
      S_CINIT: begin op = OP_CINIT; state_nxt = S_CLR; end
      S_CLR: begin
        op = OP_CSTEP;
        if (stat.sweep_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin op = OP_LOAD; state_nxt = S_DISP; end
      end
      S_DISP: begin
        if (stat.mode != MODE_ALLOC) begin
          state_nxt = S_FRD;
        end else if (!stat.fit || !stat.sel_found) begin
          op = OP_RES_NOSPACE; state_nxt = S_DONE;
        end else if (stat.table_full) begin
          op = OP_RES_FULL; state_nxt = S_DONE;
        end else begin
          op = OP_SCAN_INIT; state_nxt = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin op = OP_SCAN_RD; state_nxt = S_SCAN_CHK; end
      S_SCAN_CHK: begin
        if (stat.scan_hit) begin
          op = OP_SCAN_HIT; state_nxt = S_MRD; ret_nxt = S_TRIM;
        end else begin
          op = OP_SCAN_NEXT; state_nxt = S_SCAN_RD;
        end
      end
      S_MRD: begin op = OP_MRD; state_nxt = S_MWR; end
      S_MWR: begin op = OP_MWR; state_nxt = ret_r; end
      S_TRIM: begin
        if (stat.trim_zero) begin
          op = OP_GRANT; state_nxt = S_DONE;
        end else begin
          op = OP_TRIM;
          if (stat.trim_split) begin state_nxt = S_MRD; ret_nxt = S_TRIM; end
        end
      end
      S_FRD: begin op = OP_FRD; state_nxt = S_FCHK; end
      S_FCHK: begin
        if (stat.f_hit) begin
          op = OP_FHIT; state_nxt = S_CHUNK;
        end else if (stat.f_last) begin
          op = OP_RES_NOTFOUND; state_nxt = S_DONE;
        end else begin
          op = OP_FNEXT; state_nxt = S_FRD;
        end
      end
      S_CHUNK: begin
        if (stat.left_zero) begin
          state_nxt = S_DONE;
        end else begin
          op = OP_CHUNK; state_nxt = S_MERGE;
        end
      end
      S_MERGE: begin
        if (stat.mo_top) begin
          op = OP_MFINAL; state_nxt = S_MRD; ret_nxt = S_CHUNK;
        end else begin
          op = OP_BRD; state_nxt = S_BCHK;
        end
      end
      S_BCHK: begin
        if (stat.buddy_set) begin
          op = OP_BCLR; state_nxt = S_MERGE;
        end else begin
          op = OP_MFINAL; state_nxt = S_MRD; ret_nxt = S_CHUNK;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin op = OP_PUSH; state_nxt = S_IDLE; end
      end
      default: state_nxt = S_CINIT;
    endcase
    // a register write restarts the clear pass
    if (cfg_we) begin
      op        = OP_NONE;
      state_nxt = S_CINIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CINIT;
      ret_r   <= S_TRIM;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
    end
  end

endmodule

FILE: hdl/bfa_dp.sv
// ----------------------------------------------------------------------------
// bfa_dp
// Datapath: free bitmaps in RAM, grant table, order counts and result register.
// ----------------------------------------------------------------------------
module bfa_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bfa_pkg::dp_op_t             op,
  output bfa_pkg::dp_stat_t           stat,
  input  logic                        cfg_we,
  input  logic [bfa_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic                        in_mode,
  input  logic [bfa_pkg::BYTES_W-1:0] in_bytes,
  input  logic [bfa_pkg::FRAME_W-1:0] in_start,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_status,
  output logic [bfa_pkg::FRAME_W-1:0] out_first,
  output logic [bfa_pkg::FRAME_W-1:0] out_final
);
  import bfa_pkg::*;

  function automatic logic [POS_W-1:0] mark_pos(logic [ORD_W-1:0] o,
                                                logic [FRAME_W-1:0] f);
    logic [POS_W-1:0] p;
    p = '0;
    for (int k = 0; k < ORDERS; k++) begin
      if (o == ORD_W'(k)) p = POS_W'(mark_base(k)) + POS_W'(f >> k);
    end
    return p;
  endfunction

  logic [CHUNK_W-1:0]  usable_r;
  logic [CNT_W-1:0]    cnt_r [ORDERS];
  logic [MAX_ALLOCATIONS-1:0] valid_r;
  logic                mode_r;
  logic [BYTES_W-1:0]  req_r, used_r;
  logic [FRAME_W-1:0]  want_r, start_r, cur_r;
  logic [ORD_W-1:0]    a_ord_r, t_ord_r, m_ord_r, mo_r;
  logic [FRAME_W-1:0]  m_frame_r, mf_r, fpos_r;
  logic                m_val_r;
  logic [MARK_AW-1:0]  scan_w_r, sweep_r;
  logic [SLOT_W-1:0]   idx_r;
  logic [LEFT_W-1:0]   left_r;
  logic [1:0]          res_status_r;
  logic [FRAME_W-1:0]  res_first_r, res_final_r;
  logic                out_valid_r;
  logic [1:0]          out_status_r;
  logic [FRAME_W-1:0]  out_first_r, out_final_r;

  // mark RAM
  logic               mk_we;
  logic [MARK_AW-1:0] mk_addr;
  logic [31:0]        mk_wdata, mk_rdata;
  // grant RAM
  logic               gt_we;
  logic [SLOT_W-1:0]  gt_addr;
  logic [GRANT_W-1:0] gt_wdata, gt_rdata;

  bfa_ram #(.WIDTH(32), .DEPTH(MARK_WORDS)) u_marks (
    .clk, .we(mk_we), .addr(mk_addr), .wdata(mk_wdata), .rdata(mk_rdata)
  );
  bfa_ram #(.WIDTH(GRANT_W), .DEPTH(MAX_ALLOCATIONS)) u_grants (
    .clk, .we(gt_we), .addr(gt_addr), .wdata(gt_wdata), .rdata(gt_rdata)
  );

  // size lookups
  logic [ORD_W-1:0]  min_ord, sel_ord, chunk_ord;
  logic              fit, sel_found;
  logic [SLOT_W-1:0] free_slot;
  always_comb begin
    min_ord = '0;
    fit     = {32'd0, req_r} <= (64'(FRAME_BYTES) << (ORDERS - 1));
    for (int k = ORDERS - 1; k >= 0; k--) begin
      if ({32'd0, req_r} <= (64'(FRAME_BYTES) << k)) min_ord = ORD_W'(k);
    end
    sel_ord   = '0;
    sel_found = 1'b0;
    for (int k = ORDERS - 1; k >= 0; k--) begin
      if (ORD_W'(k) >= min_ord && cnt_r[k] != '0) begin
        sel_ord = ORD_W'(k); sel_found = 1'b1;
      end
    end
    free_slot = '0;
    for (int k = MAX_ALLOCATIONS - 1; k >= 0; k--) begin
      if (!valid_r[k]) free_slot = SLOT_W'(k);
    end
    chunk_ord = '0;
    for (int k = 0; k < ORDERS; k++) begin
      if ((LEFT_W'(1) << k) <= left_r) chunk_ord = ORD_W'(k);
    end
  end

  // scan of one bitmap word of the chosen order
  logic [POS_W-1:0] a_base, a_end, hit_pos;
  logic [31:0]      scan_bits;
  logic [4:0]       hit_bit;
  logic [FRAME_W-1:0] hit_start;
  always_comb begin
    a_base = '0;
    a_end  = '0;
    for (int k = 0; k < ORDERS; k++) begin
      if (a_ord_r == ORD_W'(k)) begin
        a_base = POS_W'(mark_base(k));
        a_end  = POS_W'(mark_base(k) + (TOTAL_FRAMES >> k));
      end
    end
    for (int j = 0; j < 32; j++) begin
      scan_bits[j] = mk_rdata[j] && ({scan_w_r, 5'(j)} >= a_base)
                     && ({scan_w_r, 5'(j)} < a_end);
    end
    hit_bit = '0;
    for (int j = 31; j >= 0; j--) begin
      if (scan_bits[j]) hit_bit = 5'(j);
    end
    hit_pos   = {scan_w_r, hit_bit};
    hit_start = FRAME_W'(hit_pos - a_base) << a_ord_r;
  end

  // clear-pass word: top-order chunks that memory provides
  localparam int TOP_BASE = mark_base(ORDERS - 1);
  logic [31:0] clr_word;
  always_comb begin
    for (int j = 0; j < 32; j++) begin
      clr_word[j] = ({sweep_r, 5'(j)} >= POS_W'(TOP_BASE))
                    && ({sweep_r, 5'(j)} < POS_W'(TOP_BASE) + POS_W'(usable_r));
    end
  end

  logic [POS_W-1:0]   m_pos, b_pos;
  logic [FRAME_W-1:0] buddy;
  logic [BYTES_W-1:0] half_bytes;
  logic [FRAME_W-1:0] half_frames;
  logic [ORD_W-1:0]   t_dn;
  logic               m_old;
  assign m_pos       = mark_pos(m_ord_r, m_frame_r);
  assign buddy       = mf_r ^ (FRAME_W'(1) << mo_r);
  assign b_pos       = mark_pos(mo_r, buddy);
  assign t_dn        = t_ord_r - ORD_W'(1);
  assign half_bytes  = BYTES_W'(FRAME_BYTES) << t_dn;
  assign half_frames = FRAME_W'(1) << t_dn;
  assign m_old       = mk_rdata[m_pos[4:0]];

  always_comb begin
    mk_we    = 1'b0;
    mk_addr  = m_pos[POS_W-1:5];
    mk_wdata = mk_rdata;
    unique case (op)
      OP_CSTEP: begin mk_we = 1'b1; mk_addr = sweep_r; mk_wdata = clr_word; end
      OP_SCAN_RD: mk_addr = scan_w_r;
      OP_MWR: begin mk_we = 1'b1; mk_wdata[m_pos[4:0]] = m_val_r; end
      OP_BRD: mk_addr = b_pos[POS_W-1:5];
      OP_BCLR: begin
        mk_we = 1'b1; mk_addr = b_pos[POS_W-1:5]; mk_wdata[b_pos[4:0]] = 1'b0;
      end
      default: ;
    endcase
  end

  assign gt_we    = (op == OP_GRANT);
  assign gt_addr  = (op == OP_GRANT) ? free_slot : idx_r;
  assign gt_wdata = {cur_r, start_r};

  always_comb begin
    stat.mode       = mode_r;
    stat.fit        = fit;
    stat.sel_found  = sel_found;
    stat.table_full = &valid_r;
    stat.scan_hit   = |scan_bits;
    stat.trim_zero  = (t_ord_r == '0);
    stat.trim_split = half_bytes >= used_r;
    stat.f_hit      = valid_r[idx_r] && (gt_rdata[FRAME_W-1:0] == want_r);
    stat.f_last     = (idx_r == SLOT_W'(MAX_ALLOCATIONS - 1));
    stat.left_zero  = (left_r == '0);
    stat.mo_top     = (mo_r == ORD_W'(ORDERS - 1));
    stat.buddy_set  = mk_rdata[b_pos[4:0]];
    stat.sweep_last = (sweep_r == MARK_AW'(MARK_WORDS - 1));
    stat.out_free   = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      usable_r    <= CHUNK_W'(TOP_CHUNKS);
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      sweep_r     <= '0;
      for (int k = 0; k < ORDERS; k++) cnt_r[k] <= '0;
    end else begin
      if (cfg_we) begin
        usable_r <= (int'(cfg_wdata) > TOP_CHUNKS) ? CHUNK_W'(TOP_CHUNKS)
                                                   : CHUNK_W'(cfg_wdata);
      end
      if (op == OP_PUSH) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (op)
        OP_CINIT: begin
          for (int k = 0; k < ORDERS - 1; k++) cnt_r[k] <= '0;
          cnt_r[ORDERS-1] <= CNT_W'(usable_r);
          valid_r <= '0;
          sweep_r <= '0;
        end
        OP_CSTEP: sweep_r <= sweep_r + MARK_AW'(1);
        OP_LOAD: begin
          mode_r       <= in_mode;
          req_r        <= in_bytes;
          want_r       <= in_start;
          idx_r        <= '0;
          res_status_r <= ST_OK;
          res_first_r  <= '0;
          res_final_r  <= '0;
        end
        OP_RES_NOSPACE:  res_status_r <= ST_NO_SPACE;
        OP_RES_FULL:     res_status_r <= ST_FULL;
        OP_RES_NOTFOUND: res_status_r <= ST_NOT_FND;
        OP_SCAN_INIT: begin
          a_ord_r  <= sel_ord;
          scan_w_r <= MARK_AW'(mark_pos(sel_ord, '0) >> 5);
        end
        OP_SCAN_NEXT: scan_w_r <= scan_w_r + MARK_AW'(1);
        OP_SCAN_HIT: begin
          start_r   <= hit_start;
          cur_r     <= hit_start;
          used_r    <= req_r;
          t_ord_r   <= a_ord_r;
          m_ord_r   <= a_ord_r;
          m_frame_r <= hit_start;
          m_val_r   <= 1'b0;
        end
        OP_MWR: begin
          if (m_old && !m_val_r) cnt_r[m_ord_r] <= cnt_r[m_ord_r] - CNT_W'(1);
          if (!m_old && m_val_r) cnt_r[m_ord_r] <= cnt_r[m_ord_r] + CNT_W'(1);
        end
        OP_TRIM: begin
          t_ord_r <= t_dn;
          if (half_bytes >= used_r) begin
            m_ord_r   <= t_dn;
            m_frame_r <= cur_r + half_frames;
            m_val_r   <= 1'b1;
          end else begin
            used_r <= used_r - half_bytes;
            cur_r  <= cur_r + half_frames;
          end
        end
        OP_GRANT: begin
          valid_r[free_slot] <= 1'b1;
          res_first_r        <= start_r;
          res_final_r        <= cur_r;
        end
        OP_FNEXT: idx_r <= idx_r + SLOT_W'(1);
        OP_FHIT: begin
          valid_r[idx_r] <= 1'b0;
          res_first_r    <= gt_rdata[FRAME_W-1:0];
          res_final_r    <= gt_rdata[GRANT_W-1:FRAME_W];
          fpos_r         <= gt_rdata[FRAME_W-1:0];
          left_r <= (gt_rdata[GRANT_W-1:FRAME_W] >= gt_rdata[FRAME_W-1:0])
                    ? LEFT_W'(gt_rdata[GRANT_W-1:FRAME_W])
                      - LEFT_W'(gt_rdata[FRAME_W-1:0]) + LEFT_W'(1)
                    : '0;
        end
        OP_CHUNK: begin
          mf_r   <= fpos_r;
          mo_r   <= chunk_ord;
          fpos_r <= fpos_r + FRAME_W'(LEFT_W'(1) << chunk_ord);
          left_r <= left_r - (LEFT_W'(1) << chunk_ord);
        end
        OP_BCLR: begin
          cnt_r[mo_r] <= cnt_r[mo_r] - CNT_W'(1);
          mf_r        <= mf_r & ~(FRAME_W'(1) << mo_r);
          mo_r        <= mo_r + ORD_W'(1);
        end
        OP_MFINAL: begin
          m_ord_r   <= mo_r;
          m_frame_r <= mf_r;
          m_val_r   <= 1'b1;
        end
        OP_PUSH: begin
          out_status_r <= res_status_r;
          out_first_r  <= res_first_r;
          out_final_r  <= res_final_r;
        end
        default: ;
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_first  = out_first_r;
  assign out_final  = out_final_r;

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the buddy frame allocator. Allocate and free beats are
// checked field by field against a behavioral model of the bitmaps and grant
// table kept here. Both stream sides stall at random, and the chunk count
// register is rewritten between phases.
// ----------------------------------------------------------------------------
module tb_top;
  import bfa_pkg::*;

  localparam int  LIMIT     = 4000000;
  localparam int  SETTLE    = 1200;
  localparam logic MODE_FREE = 1'b1;

  typedef struct packed {
    logic [1:0]         status;
    logic [FRAME_W-1:0] first;
    logic [FRAME_W-1:0] last;
  } grant_res_t;

  typedef struct {
    logic        mode;
    logic [31:0] bytes;
    logic [13:0] start;
    bit          typed;
    grant_res_t  res;
  } req_row_t;

  logic clk, rst_n;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  logic in_tvalid, in_tready, in_tuser;
  logic [47:0] in_tdata;
  logic out_tvalid, out_tready;
  logic [1:0] out_tuser;
  logic [31:0] out_tdata;

  buddy_frame_allocator DUT (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser),
    .in_tdata(in_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tuser(out_tuser), .out_tdata(out_tdata)
  );

  // model state: one free mark per aligned block of each order
  bit          free_map [ORDERS][TOTAL_FRAMES];
  bit          slot_used [MAX_ALLOCATIONS];
  logic [13:0] slot_start [MAX_ALLOCATIONS];
  logic [13:0] slot_last [MAX_ALLOCATIONS];
  int          chunk_count;

  grant_res_t  pending_grants[$];
  int          fail_count;
  int          cycle_count;
  bit          calm;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("buddy_frame_allocator test failed");
      $finish;
    end
  end

  task automatic note_error(string msg);
    fail_count++;
    if (fail_count <= 10) $display("mismatch: %s", msg);
  endtask

  function automatic bit mark_at(int o, int frame);
    if (frame >= TOTAL_FRAMES) return 0;
    return free_map[o][frame >> o];
  endfunction

  function automatic void mark_put(int o, int frame, bit v);
    if (frame < TOTAL_FRAMES) free_map[o][frame >> o] = v;
  endfunction

  function automatic void pool_init(int count);
    foreach (free_map[o, b]) free_map[o][b] = 0;
    foreach (slot_used[i]) slot_used[i] = 0;
    chunk_count = (count > TOP_CHUNKS) ? TOP_CHUNKS : count;
    for (int c = 0; c < chunk_count; c++) mark_put(ORDERS - 1, c << (ORDERS - 1), 1);
  endfunction

  function automatic void merge_back(int frame, int o);
    int buddy;
    while (o < ORDERS - 1) begin
      buddy = frame ^ (1 << o);
      if (!mark_at(o, buddy)) break;
      mark_put(o, buddy, 0);
      if (buddy < frame) frame = buddy;
      o++;
    end
    mark_put(o, frame, 1);
  endfunction

  function automatic grant_res_t serve_request(logic mode, logic [31:0] bytes,
                                               logic [13:0] want);
    grant_res_t r;
    bit hit;
    int o, base, cur, slot, left, f, co;
    longint chunk, used, half;
    r = '0;
    hit = 0; o = 0; base = 0; slot = -1;
    if (mode == MODE_ALLOC) begin
      for (int i = 0; i < ORDERS && !hit; i++) begin
        if (longint'(bytes) > (longint'(FRAME_BYTES) << i)) continue;
        for (int b = 0; b < (TOTAL_FRAMES >> i); b++)
          if (free_map[i][b]) begin
            hit = 1; o = i; base = b << i;
            break;
          end
      end
      if (!hit) r.status = ST_NO_SPACE;
      else begin
        for (int i = 0; i < MAX_ALLOCATIONS; i++)
          if (!slot_used[i]) begin slot = i; break; end
        if (slot < 0) r.status = ST_FULL;
        else begin
          chunk = longint'(FRAME_BYTES) << o;
          used = bytes;
          cur = base;
          mark_put(o, base, 0);
          while (chunk > FRAME_BYTES) begin
            half = chunk / 2;
            o--;
            if (half >= used) mark_put(o, cur + int'(half / FRAME_BYTES), 1);
            else begin
              used -= half;
              cur += int'(half / FRAME_BYTES);
            end
            chunk = half;
          end
          slot_used[slot] = 1;
          slot_start[slot] = 14'(base);
          slot_last[slot] = 14'(cur);
          r.status = ST_OK; r.first = 14'(base); r.last = 14'(cur);
        end
      end
    end else begin
      for (int i = 0; i < MAX_ALLOCATIONS; i++)
        if (slot_used[i] && slot_start[i] == want) begin slot = i; break; end
      if (slot < 0) r.status = ST_NOT_FND;
      else begin
        slot_used[slot] = 0;
        r.status = ST_OK; r.first = slot_start[slot]; r.last = slot_last[slot];
        left = (slot_last[slot] >= slot_start[slot]) ?
               slot_last[slot] - slot_start[slot] + 1 : 0;
        f = slot_start[slot];
        while (left > 0) begin
          co = ORDERS - 1;
          while (co > 0 && (1 << co) > left) co--;
          merge_back(f, co);
          f += 1 << co;
          left -= 1 << co;
        end
      end
    end
    return r;
  endfunction

  // drive one beat and hold it until taken; leaves the caller at the accepting edge
  task automatic send_beat(logic mode, logic [31:0] bytes, logic [13:0] want,
                           bit typed, grant_res_t typed_res);
    grant_res_t r;
    if (!calm && $urandom_range(99) < 8) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser  <= mode;
    in_tdata  <= {2'b00, want, bytes};
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    r = serve_request(mode, bytes, want);
    pending_grants.push_back(typed ? typed_res : r);
  endtask

  task automatic drain_results();
    while (pending_grants.size() != 0) @(posedge clk);
  endtask

  task automatic write_chunks(logic [CFG_W-1:0] v);
    in_tvalid <= 0;
    drain_results();
    repeat (SETTLE) @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    pool_init(v);
  endtask

  task automatic random_beat();
    int live[$];
    int k;
    logic [31:0] bytes;
    if ($urandom_range(99) < 55) begin
      k = $urandom_range(0, ORDERS - 1);
      if ($urandom_range(99) < 8) bytes = $urandom;
      else bytes = $urandom_range(0, FRAME_BYTES << k);
      send_beat(MODE_ALLOC, bytes, 14'($urandom), 0, '0);
    end else begin
      foreach (slot_used[i]) if (slot_used[i]) live.push_back(int'(slot_start[i]));
      if (live.size() != 0 && $urandom_range(99) < 80)
        send_beat(MODE_FREE, $urandom, 14'(live[$urandom_range(0, live.size() - 1)]),
                  0, '0);
      else
        send_beat(MODE_FREE, $urandom, 14'($urandom), 0, '0);
    end
  endtask

  // result side
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 0;
    else out_tready <= calm || ($urandom_range(99) >= 8);
  end

  always @(negedge clk) begin
    grant_res_t want_r, got;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = out_tuser;
      got.first  = out_tdata[13:0];
      got.last   = out_tdata[27:14];
      if (pending_grants.size() == 0) note_error("result beat with nothing pending");
      else begin
        want_r = pending_grants.pop_front();
        if (got.status != want_r.status)
          note_error($sformatf("status exp %0d got %0d", want_r.status, got.status));
        if (got.first != want_r.first)
          note_error($sformatf("first_frame exp %0d got %0d", want_r.first, got.first));
        if (got.last != want_r.last)
          note_error($sformatf("final_frame exp %0d got %0d", want_r.last, got.last));
      end
    end
  end

  req_row_t rows[$];

  initial begin
    int chunk_plan[5];
    int n;
    fail_count = 0;
    cycle_count = 0;
    calm = 0;
    rst_n = 0;
    cfg_we = 0;
    cfg_wdata = '0;
    in_tvalid = 0;
    in_tuser = 0;
    in_tdata = '0;
    pool_init(16);
    repeat (8) @(posedge clk);
    rst_n <= 1;

    rows = '{
      '{MODE_ALLOC, 32'd0,          14'd0,     1, '{ST_OK, 14'd0, 14'd0}},
      '{MODE_ALLOC, 32'hFFFF_FFFF,  14'd0,     1, '{ST_NO_SPACE, 14'd0, 14'd0}},
      '{MODE_ALLOC, 32'd4194305,    14'd0,     1, '{ST_NO_SPACE, 14'd0, 14'd0}},
      '{MODE_ALLOC, 32'd4194304,    14'd0,     0, '0},
      '{MODE_ALLOC, 32'd4096,       14'd0,     0, '0},
      '{MODE_ALLOC, 32'd4097,       14'd0,     0, '0},
      '{MODE_ALLOC, 32'd12288,      14'd0,     0, '0},
      '{MODE_FREE,  32'd0,          14'h3FFF,  1, '{ST_NOT_FND, 14'd0, 14'd0}},
      '{MODE_FREE,  32'hFFFF_FFFF,  14'd0,     0, '0},
      '{MODE_FREE,  32'd0,          14'd0,     1, '{ST_NOT_FND, 14'd0, 14'd0}},
      '{MODE_FREE,  32'd0,          14'd1024,  0, '0},
      '{MODE_FREE,  32'd0,          14'd4,     0, '0},
      '{MODE_ALLOC, 32'd1,          14'h3FFF,  0, '0},
      '{MODE_ALLOC, 32'd2097152,    14'd0,     0, '0},
      '{MODE_ALLOC, 32'd3000000,    14'd0,     0, '0},
      '{MODE_FREE,  32'd0,          14'd2,     0, '0},
      '{MODE_ALLOC, 32'd65536,      14'd0,     0, '0},
      '{MODE_FREE,  32'd0,          14'd1,     0, '0}
    };
    foreach (rows[i]) send_beat(rows[i].mode, rows[i].bytes, rows[i].start,
                                rows[i].typed, rows[i].res);

    // fill the grant table, then overflow it, then release everything
    write_chunks(5'd16);
    for (int i = 0; i < MAX_ALLOCATIONS + 3; i++) send_beat(MODE_ALLOC, 32'd0, 14'd0, 0, '0);
    for (int i = 0; i < MAX_ALLOCATIONS; i++) send_beat(MODE_FREE, 32'd0, 14'(i), 0, '0);

    chunk_plan = '{1, 0, 31, 16, 0};
    chunk_plan[4] = $urandom_range(2, 15);
    foreach (chunk_plan[p]) begin
      write_chunks(5'(chunk_plan[p]));
      n = (chunk_plan[p] == 0) ? 20 : 60;
      for (int i = 0; i < n; i++) begin
        calm = (p == 3 && i >= 10 && i < 50);
        if (p == 2 && i == 30) begin
          in_tvalid <= 0;
          drain_results();
        end
        random_beat();
      end
      calm = 0;
    end

    in_tvalid <= 0;
    drain_results();
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0 && pending_grants.size() == 0) begin
      $display("buddy_frame_allocator test passed");
    end else begin
      $display("buddy_frame_allocator test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/bfa_pkg.sv
hdl/bfa_ram.sv
hdl/bfa_ctrl.sv
hdl/bfa_dp.sv
hdl/buddy_frame_allocator.sv
verif/tb_top.sv
